// ===== rtl/rhre_pkg.sv =====
// ----------------------------------------------------------------------------
// rhre_pkg
// Types and constants shared by the read handshake retry engine.
// ----------------------------------------------------------------------------
package rhre_pkg;

   localparam logic [3:0] REQ_CODE_HI = 4'hF;

   localparam logic [1:0] CSR_READY_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_ACK_INTERVAL  = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_MAX_RETRIES   = 2'd3;

   localparam logic [8:0] RST_READY_TIMEOUT = 9'd300;
   localparam logic [5:0] RST_ACK_INTERVAL  = 6'd10;
   localparam logic [8:0] RST_ACK_TIMEOUT   = 9'd100;
   localparam logic [3:0] RST_MAX_RETRIES   = 4'd10;

   localparam logic       CMD_START = 1'b0;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'b0001,
      PH_WAIT_READY = 4'b0010,
      PH_RECHECK    = 4'b0100,
      PH_WAIT_DROP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] address;
      logic        ready_req;
      logic [15:0] bus_data;
   } req_type;

   typedef struct packed {
      logic        issue_request;
      logic [19:0] request_word;
      logic        ack_toggle;
      logic        done_res;
      logic        failed;
      logic [15:0] read_value;
      logic [15:0] error_count;
   } rsp_type;

   typedef struct packed {
      logic [8:0] ready_timeout;
      logic [5:0] ack_retoggle_interval;
      logic [8:0] ack_timeout;
      logic [3:0] max_retries;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] held_address;
      logic [15:0] latched_data;
      logic [8:0]  poll_count;
      logic [5:0]  toggle_count;
      logic [3:0]  retry_count;
      logic [15:0] fail_total;
   } state_type;

endpackage

// ===== rtl/rhre_step.sv =====
// ----------------------------------------------------------------------------
// rhre_step
// Next-state and result logic for one item of the read handshake.
// ----------------------------------------------------------------------------
module rhre_step (
   input  rhre_pkg::state_type cur,
   input  rhre_pkg::cfg_type   cfg,
   input  rhre_pkg::req_type   item,
   output rhre_pkg::state_type nxt,
   output rhre_pkg::rsp_type   res
);

   logic [9:0] poll_inc;
   logic [6:0] toggle_inc;
   logic       retry_over;
   logic       do_retry;
   logic       do_fail;

   assign poll_inc   = {1'b0, cur.poll_count} + 10'd1;
   assign toggle_inc = {1'b0, cur.toggle_count} + 7'd1;
   assign retry_over = ({1'b0, cur.retry_count} + 5'd1) > {1'b0, cfg.max_retries};

   always_comb begin
      nxt      = cur;
      res      = '0;
      do_retry = 1'b0;
      do_fail  = 1'b0;
      if (item.cmd == rhre_pkg::CMD_START) begin
         nxt.held_address  = item.address;
         nxt.retry_count   = '0;
         nxt.poll_count    = '0;
         nxt.phase         = rhre_pkg::PH_WAIT_READY;
         res.issue_request = 1'b1;
      end else begin
         case (cur.phase)
            rhre_pkg::PH_WAIT_READY: begin
               if (item.ready_req) begin
                  nxt.latched_data = item.bus_data;
                  nxt.phase        = rhre_pkg::PH_RECHECK;
               end else if (poll_inc > {1'b0, cfg.ready_timeout}) begin
                  do_retry = 1'b1;
               end else begin
                  nxt.poll_count = poll_inc[8:0];
               end
            end
            rhre_pkg::PH_RECHECK: begin
               if (item.ready_req) begin
                  res.ack_toggle   = 1'b1;
                  nxt.poll_count   = '0;
                  nxt.toggle_count = '0;
                  nxt.phase        = rhre_pkg::PH_WAIT_DROP;
               end else begin
                  do_retry = 1'b1;
               end
            end
            rhre_pkg::PH_WAIT_DROP: begin
               if (!item.ready_req) begin
                  res.done_res   = 1'b1;
                  res.read_value = cur.latched_data;
                  nxt.phase      = rhre_pkg::PH_IDLE;
                  nxt.poll_count = '0;
               end else begin
                  // toggle_count tracks poll count modulo the interval
                  if (cfg.ack_retoggle_interval != '0 &&
                      toggle_inc == {1'b0, cfg.ack_retoggle_interval}) begin
                     res.ack_toggle   = 1'b1;
                     nxt.toggle_count = '0;
                  end else begin
                     nxt.toggle_count = toggle_inc[5:0];
                  end
                  if (poll_inc > {1'b0, cfg.ack_timeout}) begin
                     do_fail = 1'b1;
                  end else begin
                     nxt.poll_count = poll_inc[8:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (do_retry) begin
         if (retry_over) begin
            do_fail = 1'b1;
         end else begin
            nxt.retry_count   = cur.retry_count + 4'd1;
            nxt.poll_count    = '0;
            nxt.phase         = rhre_pkg::PH_WAIT_READY;
            res.issue_request = 1'b1;
         end
      end

      if (do_fail) begin
         if (cur.fail_total != 16'hFFFF) begin
            nxt.fail_total = cur.fail_total + 16'd1;
         end
         nxt.phase      = rhre_pkg::PH_IDLE;
         nxt.poll_count = '0;
         res.done_res   = 1'b1;
         res.failed     = 1'b1;
         res.read_value = '0;
      end

      res.request_word = {rhre_pkg::REQ_CODE_HI, nxt.held_address};
      res.error_count  = nxt.fail_total;
   end

endmodule

// ===== rtl/read_handshake_retry_engine_top.sv =====
// ----------------------------------------------------------------------------
// read_handshake_retry_engine_top
// Requester side of a register-read handshake with ready/ack retries.
// ----------------------------------------------------------------------------
// An accepted item's result is registered in the output register. One item is
// taken per cycle while req_stall is low; the handshake state updates in a
// single pass. req_stall is high while a result is held and rsp_stall is high,
// and after a write to the ack interval register (retoggle phase rebuild).
// Reset (synchronous): phase idle, counters and error count zero, registers
// back to their default values, output register empty.
module read_handshake_retry_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rhre_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rhre_pkg::rsp_type rsp_data,
   input  logic              csr_wen,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_wdata
);

   rhre_pkg::cfg_type   cfg_ff;
   rhre_pkg::state_type state_ff;
   rhre_pkg::state_type state_in;
   rhre_pkg::rsp_type   rsp_ff;
   rhre_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                accept;
   logic                resync_ff;
   logic [3:0]          resync_cnt_ff;
   logic [5:0]          resync_rem_ff;
   logic [5:0]          resync_rem_in;
   logic [6:0]          resync_trial;
   logic [6:0]          resync_diff;
   logic                resync_last;

   assign req_stall = (rsp_valid_ff & rsp_stall) | resync_ff;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // poll_count modulo the new interval, one dividend bit per cycle, MSB first
   assign resync_trial  = {resync_rem_ff, state_ff.poll_count[4'd8 - resync_cnt_ff]};
   assign resync_diff   = resync_trial - {1'b0, cfg_ff.ack_retoggle_interval};
   assign resync_rem_in = (resync_trial >= {1'b0, cfg_ff.ack_retoggle_interval}) ?
                          resync_diff[5:0] : resync_trial[5:0];
   assign resync_last   = (resync_cnt_ff == 4'd8);

   rhre_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .item (req_data),
      .nxt  (state_in),
      .res  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_timeout         <= rhre_pkg::RST_READY_TIMEOUT;
         cfg_ff.ack_retoggle_interval <= rhre_pkg::RST_ACK_INTERVAL;
         cfg_ff.ack_timeout           <= rhre_pkg::RST_ACK_TIMEOUT;
         cfg_ff.max_retries           <= rhre_pkg::RST_MAX_RETRIES;
      end else if (csr_wen) begin
         case (csr_index)
            rhre_pkg::CSR_READY_TIMEOUT: cfg_ff.ready_timeout         <= csr_wdata;
            rhre_pkg::CSR_ACK_INTERVAL:  cfg_ff.ack_retoggle_interval <= csr_wdata[5:0];
            rhre_pkg::CSR_ACK_TIMEOUT:   cfg_ff.ack_timeout           <= csr_wdata;
            rhre_pkg::CSR_MAX_RETRIES:   cfg_ff.max_retries           <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resync_ff     <= 1'b0;
         resync_cnt_ff <= '0;
         resync_rem_ff <= '0;
      end else if (csr_wen && csr_index == rhre_pkg::CSR_ACK_INTERVAL) begin
         resync_ff     <= 1'b1;
         resync_cnt_ff <= '0;
         resync_rem_ff <= '0;
      end else if (resync_ff) begin
         resync_cnt_ff <= resync_cnt_ff + 4'd1;
         resync_rem_ff <= resync_rem_in;
         if (resync_last) begin
            resync_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= rhre_pkg::PH_IDLE;
         state_ff.held_address <= '0;
         state_ff.latched_data <= '0;
         state_ff.poll_count   <= '0;
         state_ff.toggle_count <= '0;
         state_ff.retry_count  <= '0;
         state_ff.fail_total   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end else if (resync_ff && resync_last) begin
         state_ff.toggle_count <= resync_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/rhre_checker.sv =====
// ----------------------------------------------------------------------------
// rhre_checker
// Port-level checks on the read handshake retry engine results.
// ----------------------------------------------------------------------------
module rhre_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rhre_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failed |-> rsp_data.done_res && rsp_data.read_value == 16'd0)
      else $error("failed read without done or with nonzero value");

   a_issue_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.issue_request |-> !rsp_data.done_res && !rsp_data.ack_toggle)
      else $error("request issued together with done or ack");

   a_success_no_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res && !rsp_data.failed |-> !rsp_data.ack_toggle)
      else $error("ack toggled on successful completion");

endmodule

bind read_handshake_retry_engine_top rhre_checker u_rhre_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the read handshake retry engine against an in-bench prediction of
// the request, ready, acknowledge and retry sequence. Directed items cover
// the field extremes, restart while busy, idle ticks, zero timeouts and an
// acknowledge toggle that coincides with a failure. Random read sequences
// then run under several register settings, with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic CMD_TICK   = ~rhre_pkg::CMD_START;
   localparam int   IDLE_LIMIT = 2000;

   class handshake_scoreboard;
      logic [8:0]          ready_timeout;
      logic [5:0]          ack_interval;
      logic [8:0]          ack_timeout;
      logic [3:0]          max_retries;
      rhre_pkg::phase_type phase;
      logic [15:0]         held_address;
      logic [15:0]         latched_data;
      logic [8:0]          poll_count;
      logic [3:0]          retry_count;
      logic [15:0]         fail_total;
      rhre_pkg::rsp_type   outcome;
      rhre_pkg::rsp_type   expected_rsp[$];
      int                  mismatches;
      int                  sent_items;

      function new();
         ready_timeout = rhre_pkg::RST_READY_TIMEOUT;
         ack_interval  = rhre_pkg::RST_ACK_INTERVAL;
         ack_timeout   = rhre_pkg::RST_ACK_TIMEOUT;
         max_retries   = rhre_pkg::RST_MAX_RETRIES;
         phase         = rhre_pkg::PH_IDLE;
         held_address  = '0;
         latched_data  = '0;
         poll_count    = '0;
         retry_count   = '0;
         fail_total    = '0;
         mismatches    = 0;
         sent_items    = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [8:0] value);
         case (index)
            rhre_pkg::CSR_READY_TIMEOUT: ready_timeout = value;
            rhre_pkg::CSR_ACK_INTERVAL:  ack_interval  = value[5:0];
            rhre_pkg::CSR_ACK_TIMEOUT:   ack_timeout   = value;
            rhre_pkg::CSR_MAX_RETRIES:   max_retries   = value[3:0];
            default: ;
         endcase
      endfunction

      function void give_up();
         if (fail_total != 16'hFFFF) fail_total++;
         phase = rhre_pkg::PH_IDLE;
         poll_count = '0;
         outcome.done_res = 1'b1;
         outcome.failed = 1'b1;
         outcome.read_value = '0;
      endfunction

      function void reissue();
         if (retry_count + 1 > max_retries) begin
            give_up();
         end else begin
            retry_count++;
            poll_count = '0;
            phase = rhre_pkg::PH_WAIT_READY;
            outcome.issue_request = 1'b1;
         end
      endfunction

      function void note_request(rhre_pkg::req_type item);
         int unsigned polls;
         outcome = '0;
         sent_items++;
         if (item.cmd == rhre_pkg::CMD_START) begin
            held_address = item.address;
            retry_count = '0;
            poll_count = '0;
            phase = rhre_pkg::PH_WAIT_READY;
            outcome.issue_request = 1'b1;
         end else begin
            case (phase)
               rhre_pkg::PH_WAIT_READY: begin
                  if (item.ready_req) begin
                     latched_data = item.bus_data;
                     phase = rhre_pkg::PH_RECHECK;
                  end else begin
                     polls = poll_count + 1;
                     if (polls > ready_timeout) reissue();
                     else poll_count = polls[8:0];
                  end
               end
               rhre_pkg::PH_RECHECK: begin
                  if (item.ready_req) begin
                     outcome.ack_toggle = 1'b1;
                     poll_count = '0;
                     phase = rhre_pkg::PH_WAIT_DROP;
                  end else begin
                     reissue();
                  end
               end
               rhre_pkg::PH_WAIT_DROP: begin
                  if (!item.ready_req) begin
                     outcome.done_res = 1'b1;
                     outcome.read_value = latched_data;
                     phase = rhre_pkg::PH_IDLE;
                     poll_count = '0;
                  end else begin
                     polls = poll_count + 1;
                     if (ack_interval != 0 && polls % ack_interval == 0)
                        outcome.ack_toggle = 1'b1;
                     if (polls > ack_timeout) give_up();
                     else poll_count = polls[8:0];
                  end
               end
               default: ;
            endcase
         end
         outcome.request_word = {rhre_pkg::REQ_CODE_HI, held_address};
         outcome.error_count = fail_total;
         expected_rsp.push_back(outcome);
      endfunction

      function void check_field(string field, logic [19:0] want, logic [19:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rhre_pkg::rsp_type got);
         rhre_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("result with no item pending");
            mismatches++;
            return;
         end
         want = expected_rsp.pop_front();
         check_field("issue_request", want.issue_request, got.issue_request);
         check_field("request_word", want.request_word, got.request_word);
         check_field("ack_toggle", want.ack_toggle, got.ack_toggle);
         check_field("done_res", want.done_res, got.done_res);
         check_field("failed", want.failed, got.failed);
         check_field("read_value", want.read_value, got.read_value);
         check_field("error_count", want.error_count, got.error_count);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rhre_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rhre_pkg::rsp_type rsp_data;
   logic              csr_wen = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [8:0]        csr_wdata = '0;

   handshake_scoreboard sb = new();

   int   burst_left = 0;
   int   idle_cycles = 0;
   int   stall_mode = 0;
   int   mode_left = 0;
   int   stall_run = 0;
   logic stall_next;

   read_handshake_retry_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // item and result monitor, plus watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver stall pattern: modes of none, light and heavy stalling
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         mode_left <= 0;
         stall_run <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            1:       stall_next = ($urandom_range(0, 3) == 0);
            2:       stall_next = ($urandom_range(0, 9) < 6);
            default: stall_next = 1'b0;
         endcase
         if (stall_run >= 8) stall_next = 1'b0;
         stall_run <= stall_next ? stall_run + 1 : 0;
         rsp_stall <= stall_next;
      end
   end

   function automatic rhre_pkg::req_type start_item(logic [15:0] address);
      rhre_pkg::req_type item;
      item.cmd = rhre_pkg::CMD_START;
      item.address = address;
      item.ready_req = 1'($urandom_range(0, 1));
      item.bus_data = 16'($urandom);
      return item;
   endfunction

   function automatic rhre_pkg::req_type tick_item(logic ready, logic [15:0] bus);
      rhre_pkg::req_type item;
      item.cmd = CMD_TICK;
      item.address = 16'($urandom);
      item.ready_req = ready;
      item.bus_data = bus;
      return item;
   endfunction

   // poll count for a wait: mostly short, sometimes around the limit
   function automatic int pick_count(int unsigned limit);
      int unsigned cap;
      int          k;
      cap = (limit < 64) ? limit : 64;
      k = $urandom_range(0, 39);
      if (k < 20) return $urandom_range(0, 3);
      if (k < 30) return $urandom_range(0, cap + 1);
      if (limit <= 64)
         return (limit == 0) ? $urandom_range(0, 1) : limit - 1 + $urandom_range(0, 2);
      if (k == 39) return limit + 1;
      return $urandom_range(0, cap);
   endfunction

   task automatic send_item(rhre_pkg::req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_config(logic [8:0] rt, logic [5:0] iv, logic [8:0] at, logic [3:0] mr);
      logic [8:0] values[4];
      values = '{rt, {3'b0, iv}, at, {5'b0, mr}};
      for (int i = 0; i < 4; i++) begin
         csr_wen <= 1'b1;
         csr_index <= i[1:0];
         csr_wdata <= values[i];
         @(posedge clock);
         sb.write_register(i[1:0], values[i]);
      end
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_read_sequence();
      int attempts;
      int waits;
      int holds;
      send_item(start_item(16'($urandom)));
      attempts = ($urandom_range(0, 7) == 0) ? sb.max_retries + 2 : $urandom_range(1, 3);
      for (int a = 0; a < attempts; a++) begin
         waits = pick_count(sb.ready_timeout);
         repeat (waits) send_item(tick_item(1'b0, 16'($urandom)));
         send_item(tick_item(1'b1, 16'($urandom)));
         if (a + 1 < attempts) begin
            send_item(tick_item(1'b0, 16'($urandom)));
         end else begin
            send_item(tick_item(1'b1, 16'($urandom)));
            holds = pick_count(sb.ack_timeout);
            repeat (holds) send_item(tick_item(1'b1, 16'($urandom)));
            send_item(tick_item(1'b0, 16'($urandom)));
         end
      end
   endtask

   task automatic send_noise();
      rhre_pkg::req_type item;
      repeat ($urandom_range(1, 6)) begin
         item.address = 16'($urandom);
         item.ready_req = 1'($urandom_range(0, 1));
         item.bus_data = 16'($urandom);
         item.cmd = ($urandom_range(0, 3) == 0) ? rhre_pkg::CMD_START : CMD_TICK;
         send_item(item);
      end
   endtask

   task automatic run_random(int target);
      int stop_at;
      stop_at = sb.sent_items + target;
      while (sb.sent_items < stop_at) begin
         if ($urandom_range(0, 6) == 0) send_noise();
         else run_read_sequence();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: idle tick, restart while busy, lost ready, ack and drop
      send_item(tick_item(1'b1, 16'h0000));
      send_item(start_item(16'hFFFF));
      send_item(start_item(16'h0000));
      send_item(tick_item(1'b0, 16'h0000));
      send_item(tick_item(1'b1, 16'hFFFF));
      send_item(tick_item(1'b0, 16'($urandom)));
      send_item(tick_item(1'b1, 16'h5A3C));
      send_item(tick_item(1'b1, 16'($urandom)));
      send_item(tick_item(1'b1, 16'($urandom)));
      send_item(tick_item(1'b0, 16'($urandom)));
      drain();

      // zero ready timeout, no retries; ack toggle lands on the failing poll
      apply_config(9'd0, 6'd2, 9'd1, 4'd0);
      send_item(start_item(16'h8001));
      send_item(tick_item(1'b0, 16'($urandom)));
      send_item(start_item(16'h7FFE));
      repeat (4) send_item(tick_item(1'b1, 16'($urandom)));

      for (int p = 0; p < 7; p++) begin
         drain();
         case (p)
            0: apply_config(9'd0, 6'd0, 9'd0, 4'd0);
            1: apply_config(9'd1, 6'd1, 9'd1, 4'd0);
            2: apply_config(9'd511, 6'd63, 9'd511, 4'd15);
            3: apply_config(9'($urandom_range(1, 12)), 6'($urandom_range(1, 6)),
                            9'($urandom_range(1, 16)), 4'($urandom_range(0, 3)));
            4: apply_config(9'($urandom_range(1, 3)), 6'($urandom_range(1, 4)),
                            9'($urandom_range(1, 8)), 4'd15);
            5: apply_config(9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
                            9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)));
            default: apply_config(9'($urandom_range(1, 20)), 6'($urandom_range(1, 8)),
                                  9'($urandom_range(1, 24)), 4'($urandom_range(0, 6)));
         endcase
         run_random((p == 6) ? 250 : 180);
      end

      drain();
      repeat (4) @(posedge clock);
      if (sb.expected_rsp.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_rsp.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
